// File: rtl/core/ptrs_pkg.sv
// Package for the periodic task release scheduler: commands, status codes,
// slot geometry, the slot record and request/response types. No dependencies.
package ptrs_pkg;

   localparam int SLOTS      = 8;
   localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int MASK_W     = 8;
   localparam int TICK_W     = 64;
   localparam int TIME_W     = 32;
   // slot record: callback mark, period, delay
   localparam int REC_W      = 1 + TIME_W + TIME_W;

   typedef enum logic [1:0] {
      CMD_TICK     = 2'd0,
      CMD_REGISTER = 2'd1,
      CMD_CLEAR    = 2'd2,
      CMD_NONE     = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_NO_DESC = 2'd1,
      ST_RANGE   = 2'd2,
      ST_TAKEN   = 2'd3
   } status_type;

   typedef struct packed {
      logic              cb;
      logic [TIME_W-1:0] period;
      logic [TIME_W-1:0] delay;
   } slot_rec_type;

   typedef struct packed {
      logic [1:0]  cmd;
      logic        descriptor_valid;
      logic [7:0]  slot_index;
      logic [31:0] period_ticks;
      logic [31:0] first_delay_ticks;
      logic        has_callback;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] fire_mask;
   } rsp_type;

endpackage

// File: rtl/core/ptrs_if.sv
// Valid/ready channel interfaces for request and response transactions.
// Depends on ptrs_pkg.
interface ptrs_req_if import ptrs_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface ptrs_rsp_if import ptrs_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/ptrs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module ptrs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

// File: rtl/core/ptrs_mod.sv
// Iterative 64-by-32 remainder unit, restoring, one quotient bit a cycle.
// Depends on ptrs_pkg.
module ptrs_mod import ptrs_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [TICK_W-1:0] dividend,
   input  logic [TIME_W-1:0] divisor,
   output logic              done,
   output logic              rem_zero
);
   localparam int CNT_W = $clog2(TICK_W + 1);

   logic [TICK_W-1:0] quo_ff, quo_in;
   logic [TIME_W:0]   rem_ff, rem_in;
   logic [TIME_W-1:0] div_ff, div_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [TIME_W:0]   trial;

   // one shift-subtract step per cycle
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[TIME_W-1:0], quo_ff[TICK_W-1]};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
         cnt_in  = CNT_W'(TICK_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[TICK_W-2:0], 1'b0};
         if (trial >= {1'b0, div_ff}) begin
            rem_in = trial - {1'b0, div_ff};
         end else begin
            rem_in = trial;
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done     = done_ff;
   assign rem_zero = (rem_ff == '0);
endmodule

// File: rtl/core/periodic_task_release_scheduler.sv
// Channel   | Dir | Payload                                  | Handshake
// req       | in  | cmd, descriptor, slot, period, delay, cb | valid/ready
// rsp       | out | status, fire_mask                        | valid/ready
//
// One request at a time. Register and clear go straight to the response;
// a tick reads each slot record from the slot RAM and, for a due slot, runs
// the bit-serial remainder unit. Synchronous reset clears occupancy and tick
// count. The response sits in an output register; req.ready stays low until
// it is taken.
// Depends on ptrs_pkg, ptrs_if, ptrs_ram, ptrs_mod.
module periodic_task_release_scheduler import ptrs_pkg::*; (
   input logic clock,
   input logic reset,
   ptrs_req_if.sink   req,
   ptrs_rsp_if.source rsp
);
   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_READ = 6'b000010,
      S_EVAL = 6'b000100,
      S_MOD  = 6'b001000,
      S_WAIT = 6'b010000,
      S_RESP = 6'b100000
   } state_type;

   state_type         state_ff, state_in;
   logic [TICK_W-1:0] tick_ff, tick_in;
   logic [SLOTS-1:0]  used_ff, used_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [MASK_W-1:0] mask_ff, mask_in;
   rsp_type           out_ff, out_in;
   slot_rec_type      rec_ff, rec_in;

   logic              wr_en;
   logic [SLOT_W-1:0] wr_addr;
   slot_rec_type      wr_rec, rd_rec;
   logic              mod_start, mod_done, mod_zero;
   logic              reg_ok;
   logic [SLOTS-1:0]  slot_bit;

   ptrs_ram #(.WIDTH(REC_W), .DEPTH(SLOTS)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_rec),
      .rd_addr (slot_ff),
      .rd_data (rd_rec)
   );

   // divisor is taken from the RAM output in the cycle the remainder starts
   ptrs_mod u_mod (
      .clock    (clock),
      .reset    (reset),
      .start    (mod_start),
      .dividend (tick_ff),
      .divisor  (rd_rec.period),
      .done     (mod_done),
      .rem_zero (mod_zero)
   );

   assign req.ready = (state_ff == S_IDLE);
   assign rsp.valid = (state_ff == S_RESP);
   assign rsp.data  = out_ff;
   assign reg_ok    = req.data.descriptor_valid
                   && (req.data.slot_index < 8'(SLOTS))
                   && !used_ff[req.data.slot_index[SLOT_W-1:0]];
   assign slot_bit  = SLOTS'(1) << slot_ff;

   // sequencer: dispatch, per-slot walk, response
   always_comb begin
      state_in  = state_ff;
      tick_in   = tick_ff;
      used_in   = used_ff;
      slot_in   = slot_ff;
      mask_in   = mask_ff;
      out_in    = out_ff;
      rec_in    = rec_ff;
      wr_en     = 1'b0;
      wr_addr   = slot_ff;
      wr_rec    = rec_ff;
      mod_start = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               out_in = '0;
               priority case (req.data.cmd)
                  CMD_TICK: begin
                     tick_in  = tick_ff + 1'b1;
                     slot_in  = '0;
                     mask_in  = '0;
                     state_in = S_READ;
                  end
                  CMD_REGISTER: begin
                     if (!req.data.descriptor_valid) begin
                        out_in.status = ST_NO_DESC;
                     end else if (req.data.slot_index >= 8'(SLOTS)) begin
                        out_in.status = ST_RANGE;
                     end else if (!reg_ok) begin
                        out_in.status = ST_TAKEN;
                     end else begin
                        out_in.status = ST_OK;
                        wr_en   = 1'b1;
                        wr_addr = req.data.slot_index[SLOT_W-1:0];
                        wr_rec  = '{cb: req.data.has_callback,
                                    period: req.data.period_ticks,
                                    delay: req.data.first_delay_ticks};
                        used_in[req.data.slot_index[SLOT_W-1:0]] = 1'b1;
                     end
                     state_in = S_RESP;
                  end
                  CMD_CLEAR: begin
                     tick_in  = '0;
                     state_in = S_RESP;
                  end
                  default: state_in = S_RESP;
               endcase
            end
         end
         // RAM read issued with slot_ff as address
         S_READ: state_in = S_EVAL;
         S_EVAL: begin
            rec_in = rd_rec;
            if (!used_ff[slot_ff] || !rd_rec.cb) begin
               state_in = S_WAIT;
            end else if (rd_rec.delay == '0 && rd_rec.period != '0) begin
               mod_start = 1'b1;
               state_in  = S_MOD;
            end else begin
               if (rd_rec.delay != '0) begin
                  wr_en  = 1'b1;
                  wr_rec = rd_rec;
                  wr_rec.delay = rd_rec.delay - 1'b1;
               end
               state_in = S_WAIT;
            end
         end
         S_MOD: begin
            if (mod_done) begin
               if (mod_zero) begin
                  mask_in = mask_ff | MASK_W'(slot_bit);
               end
               state_in = S_WAIT;
            end
         end
         // advance to next slot or finish
         S_WAIT: begin
            if (slot_ff == SLOT_W'(SLOTS - 1)) begin
               out_in.fire_mask = mask_ff;
               state_in = S_RESP;
            end else begin
               slot_in  = slot_ff + 1'b1;
               state_in = S_READ;
            end
         end
         S_RESP: begin
            if (rsp.ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         tick_ff  <= '0;
         used_ff  <= '0;
      end else begin
         state_ff <= state_in;
         tick_ff  <= tick_in;
         used_ff  <= used_in;
      end
      slot_ff <= slot_in;
      mask_ff <= mask_in;
      out_ff  <= out_in;
      rec_ff  <= rec_in;
   end
endmodule

// File: tb/sv/ptrs_release_checker.sv
// Checker for the periodic task release scheduler: watches the request and
// response channels, predicts each response and compares. Depends on ptrs_pkg.
`timescale 1ns / 100ps
module ptrs_release_checker import ptrs_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_data,
   output int      mismatch_count,
   output int      pending_count
);

   // predicted scheduler state
   logic [TICK_W-1:0] tick_count;
   logic              used [SLOTS];
   slot_rec_type      rec  [SLOTS];
   rsp_type           expected_rsps [$];

   assign pending_count = expected_rsps.size();

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
      mismatch_count++;
   endtask

   function automatic rsp_type predict_rsp(input req_type r);
      rsp_type o;
      o = '0;
      case (cmd_type'(r.cmd))
         CMD_TICK: begin
            tick_count = tick_count + 1;
            for (int s = 0; s < SLOTS; s++) begin
               if (used[s] && rec[s].cb) begin
                  if (rec[s].delay == 0 && rec[s].period != 0 &&
                      (tick_count % TICK_W'(rec[s].period)) == 0) begin
                     if (s < MASK_W) o.fire_mask[s] = 1'b1;
                  end else if (rec[s].delay != 0) begin
                     rec[s].delay = rec[s].delay - 1;
                  end
               end
            end
         end
         CMD_REGISTER: begin
            if (!r.descriptor_valid) o.status = ST_NO_DESC;
            else if (r.slot_index >= SLOTS) o.status = ST_RANGE;
            else if (used[r.slot_index]) o.status = ST_TAKEN;
            else begin
               used[r.slot_index] = 1'b1;
               rec[r.slot_index] = '{r.has_callback, r.period_ticks, r.first_delay_ticks};
            end
         end
         CMD_CLEAR: tick_count = '0;
         default: ;
      endcase
      return o;
   endfunction

   // predict on accepted requests, compare accepted responses
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         tick_count = '0;
         for (int s = 0; s < SLOTS; s++) used[s] = 1'b0;
         mismatch_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               report_mismatch("unexpected transaction", int'(rsp_data), 0);
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_data.status != want.status)
                  report_mismatch("status", rsp_data.status, want.status);
               if (rsp_data.fire_mask != want.fire_mask)
                  report_mismatch("fire_mask", rsp_data.fire_mask, want.fire_mask);
            end
         end
         if (req_valid && req_ready) expected_rsps.push_back(predict_rsp(req_data));
      end
   end

endmodule

// File: tb/sv/periodic_task_release_scheduler_test.sv
// Testbench top for the scheduler: clock, reset, stimulus and verdict.
// Depends on ptrs_pkg, ptrs_if, the scheduler and ptrs_release_checker.
`timescale 1ns / 100ps
module periodic_task_release_scheduler_test;
   import ptrs_pkg::*;

   logic clock;
   logic reset;
   int   mismatch_count;
   int   pending_count;
   int   send_idle_pct;
   int   recv_stall_pct;

   ptrs_req_if req ();
   ptrs_rsp_if rsp ();

   periodic_task_release_scheduler u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req.sink),
      .rsp   (rsp.source)
   );

   ptrs_release_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req.valid),
      .req_ready      (req.ready),
      .req_data       (req.data),
      .rsp_valid      (rsp.valid),
      .rsp_ready      (rsp.ready),
      .rsp_data       (rsp.data),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // receiver stalls at the phase's rate
   always @(posedge clock) begin
      rsp.ready <= reset ? 1'b0 : ($urandom_range(99) >= recv_stall_pct);
   end

   // send one transaction, idling at random first; valid stays high after
   // acceptance so the next transaction can follow back to back
   task automatic send_req(input req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid <= 1'b1;
      req.data  <= r;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
   endtask

   function automatic req_type make_register(input logic dv, input logic [7:0] idx,
                                             input logic [31:0] per,
                                             input logic [31:0] dly, input logic cb);
      req_type r;
      r = '{CMD_REGISTER, dv, idx, per, dly, cb};
      return r;
   endfunction

   function automatic req_type random_req();
      req_type r;
      int pick;
      r.cmd               = CMD_TICK;
      r.descriptor_valid  = 1'($urandom);
      r.slot_index        = 8'($urandom);
      r.period_ticks      = $urandom;
      r.first_delay_ticks = $urandom;
      r.has_callback      = 1'($urandom);
      pick = $urandom_range(99);
      if (pick < 80) r.cmd = CMD_TICK;
      else if (pick < 92) r.cmd = CMD_REGISTER;
      else if (pick < 97) r.cmd = CMD_CLEAR;
      else r.cmd = CMD_NONE;
      if (r.cmd == CMD_REGISTER && $urandom_range(3) != 0) begin
         // mostly short periods and delays so slots release often
         r.descriptor_valid = 1'b1;
         if ($urandom_range(3) != 0) r.slot_index = 8'($urandom_range(SLOTS - 1));
         if ($urandom_range(4) != 0) r.period_ticks = $urandom_range(12);
         if ($urandom_range(4) != 0) r.first_delay_ticks = $urandom_range(6);
         if ($urandom_range(4) != 0) r.has_callback = 1'b1;
      end
      return r;
   endfunction

   // stop sending and wait until every expected response has come
   task automatic drain();
      req.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   initial begin
      req_type r;
      req.valid      = 1'b0;
      req.data       = '0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      reset          = 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: every status, field extremes, unused command, clear
      send_req('{CMD_TICK, 1'b0, 8'd0, 32'd0, 32'd0, 1'b0});
      send_req(make_register(1'b0, 8'd0, 32'd1, 32'd0, 1'b1));
      send_req(make_register(1'b1, 8'hFF, '1, '1, 1'b1));
      send_req(make_register(1'b1, 8'(SLOTS), 32'd1, 32'd0, 1'b1));
      send_req(make_register(1'b1, 8'd0, 32'd1, 32'd0, 1'b1));
      send_req(make_register(1'b1, 8'd0, 32'd2, 32'd0, 1'b1));
      send_req(make_register(1'b1, 8'd1, 32'd3, 32'd2, 1'b1));
      send_req(make_register(1'b1, 8'd2, 32'd0, 32'd0, 1'b1));
      send_req(make_register(1'b1, 8'd3, 32'd1, 32'd0, 1'b0));
      send_req(make_register(1'b1, 8'd7, '1, '1, 1'b1));
      repeat (6) send_req('{CMD_TICK, 1'b0, 8'd0, 32'd0, 32'd0, 1'b0});
      send_req('{CMD_CLEAR, 1'b1, 8'hFF, '1, '1, 1'b1});
      send_req('{CMD_NONE, 1'b1, 8'hFF, '1, '1, 1'b1});
      repeat (3) send_req('{CMD_TICK, 1'b1, 8'hFF, '1, '1, 1'b1});
      drain();

      // random phases: none, sender idle, receiver stall, both
      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct  = (phase == 1) ? 48 : (phase == 3) ? 9 : 0;
         recv_stall_pct = (phase == 2) ? 48 : (phase == 3) ? 9 : 0;
         for (int i = 0; i < 250; i++) begin
            r = random_req();
            send_req(r);
            // sender holds off until all responses are in
            if (i == 125) drain();
         end
      end

      drain();
      repeat (SLOTS * 70 + 20) @(posedge clock);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // watchdog
   initial begin
      #(64'd200_000_000);
      $display("end of test: mismatches");
      $finish;
   end

endmodule

// File: sim.f
rtl/core/ptrs_pkg.sv
rtl/core/ptrs_if.sv
rtl/core/ptrs_ram.sv
rtl/core/ptrs_mod.sv
rtl/core/periodic_task_release_scheduler.sv
tb/sv/ptrs_release_checker.sv
tb/sv/periodic_task_release_scheduler_test.sv
